// File: src/cdm_pkg.sv
// ----------------------------------------------------------------------------
// cdm_pkg
// Shared types and constants of the curvature drive mixer: beat structs,
// register indexes, fixed-point widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cdm_pkg;

	// Fixed-point format of every power value.
	localparam int FRAC_BITS = 14;

	// Field and register widths.
	localparam int IO_W      = 16;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W     = 17;

	// Datapath widths.
	localparam int MUL_W  = 18;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int LR_W   = 20;
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int REM_W  = LR_W + 1;
	localparam int CNT_W  = $clog2(QUO_W);

	localparam logic signed [LR_W-1:0]  ONE_LR  = LR_W'(longint'(1) << FRAC_BITS);
	localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(longint'(1) << FRAC_BITS);
	localparam logic signed [MUL_W-1:0] ONE_MUL = MUL_W'(longint'(1) << FRAC_BITS);

	localparam logic signed [SUM_W-1:0] ACC_MAX_S = SUM_W'((longint'(1) << (ACC_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] ACC_MIN_S = -ACC_MAX_S - SUM_W'(1);

	localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(3277);
	localparam logic [CFG_W-1:0] ALPHA_RST     = CFG_W'(1638);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_ALPHA     = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [IO_W-1:0] throttle;
		logic signed [IO_W-1:0] rotation;
		logic                   quick_turn;
	} in_beat_t;

	typedef struct packed {
		logic signed [IO_W-1:0] left_power;
		logic signed [IO_W-1:0] right_power;
	} out_beat_t;

	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

	// Commands from the controller to the datapath, one step each.
	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic mix;
		logic desat;
		logic norm;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
	} dp_status_t;

endpackage

// File: src/cdm_ctrl.sv
// ----------------------------------------------------------------------------
// cdm_ctrl
// Sequencer of the mixer: steps the datapath through multiply, mix,
// desaturate, normalize and divide, and owns the output valid flag.
// ----------------------------------------------------------------------------
module cdm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cdm_pkg::dp_status_t status,
	output cdm_pkg::dp_cmd_t    cmd
);
	import cdm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_MIX,
		S_DESAT,
		S_NORM,
		S_DIV,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic              div_last;
	logic              slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign div_last  = (cnt_q == CNT_W'(QUO_W - 1));
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.mul_a    = (state_q == S_MUL_A);
		cmd.mul_b    = (state_q == S_MUL_B);
		cmd.mix      = (state_q == S_MIX);
		cmd.desat    = (state_q == S_DESAT);
		cmd.norm     = (state_q == S_NORM);
		cmd.div_step = (state_q == S_DIV) && status.need_div;
		cmd.out_load = (state_q == S_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_MIX;
				S_MIX:   state_q <= S_DESAT;
				S_DESAT: state_q <= S_NORM;
				S_NORM: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!status.need_div || div_last) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: src/cdm_datapath.sv
// ----------------------------------------------------------------------------
// cdm_datapath
// Arithmetic of the mixer: configuration registers, quick-stop accumulator,
// shared multiplier, side mixing, desaturation and two radix-2 dividers.
// ----------------------------------------------------------------------------
module cdm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cdm_pkg::cfg_wr_t    cfg,
	input  cdm_pkg::in_beat_t   in_data,
	input  cdm_pkg::dp_cmd_t    cmd,
	output cdm_pkg::dp_status_t status,
	output cdm_pkg::out_beat_t  out_data
);
	import cdm_pkg::*;

	logic [CFG_W-1:0]         thresh_q;
	logic [CFG_W-1:0]         alpha_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [IO_W-1:0]   thr_q;
	logic signed [IO_W-1:0]   rot_q;
	logic [IO_W:0]            mag_thr_q;
	logic                     quick_q;
	logic                     below_q;

	logic signed [PROD_W-1:0] prod_a_q;
	logic signed [PROD_W-1:0] prod_b_q;
	logic signed [LR_W-1:0]   left_q;
	logic signed [LR_W-1:0]   right_q;

	logic [LR_W-1:0]          big_q;
	logic                     sign_l_q;
	logic                     sign_r_q;
	logic                     need_div_q;
	logic [REM_W-1:0]         rem_l_q;
	logic [REM_W-1:0]         rem_r_q;
	logic [QUO_W-1:0]         quo_l_q;
	logic [QUO_W-1:0]         quo_r_q;
	out_beat_t                out_q;

	logic signed [IO_W:0]     thr_ext;
	logic [IO_W:0]            mag_thr;
	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  filt;
	logic signed [ACC_W-1:0]  filt_sat;
	logic signed [LR_W-1:0]   ang;
	logic signed [LR_W-1:0]   desat_l;
	logic signed [LR_W-1:0]   desat_r;
	logic [LR_W-1:0]          mag_l;
	logic [LR_W-1:0]          mag_r;
	logic [LR_W-1:0]          big;
	logic                     ge_l;
	logic                     ge_r;
	logic [REM_W-1:0]         diff_l;
	logic [REM_W-1:0]         diff_r;
	logic signed [IO_W-1:0]   q_l;
	logic signed [IO_W-1:0]   q_r;

	assign status.need_div = need_div_q;
	assign out_data        = out_q;

	// Throttle magnitude at load time.
	assign thr_ext = (IO_W + 1)'(in_data.throttle);
	assign mag_thr = thr_ext[IO_W] ? (IO_W + 1)'(-thr_ext) : (IO_W + 1)'(thr_ext);

	// Shared multiplier operands.
	always_comb begin
		if (cmd.mul_a) begin
			if (quick_q) begin
				op_a = ONE_MUL - $signed(MUL_W'(alpha_q));
				op_b = MUL_W'(acc_q);
			end else begin
				op_a = $signed(MUL_W'(mag_thr_q));
				op_b = MUL_W'(rot_q);
			end
		end else begin
			op_a = $signed(MUL_W'(alpha_q));
			op_b = MUL_W'(rot_q) <<< 1;
		end
	end
	assign prod = op_a * op_b;

	// Filter sum, floor shift and saturation to the accumulator range.
	assign filt = (SUM_W'(prod_a_q) + SUM_W'(prod_b_q)) >>> FRAC_BITS;
	always_comb begin
		priority if (filt > ACC_MAX_S) begin
			filt_sat = ACC_W'(ACC_MAX_S);
		end else if (filt < ACC_MIN_S) begin
			filt_sat = ACC_W'(ACC_MIN_S);
		end else begin
			filt_sat = ACC_W'(filt);
		end
	end

	assign ang = quick_q ? LR_W'(rot_q)
	                     : LR_W'(prod_a_q >>> FRAC_BITS) - LR_W'(acc_q);

	// In quick-turn mode, the side that overflows is pulled back and the excess moves to the other.
	always_comb begin
		desat_l = left_q;
		desat_r = right_q;
		if (quick_q) begin
			priority if (left_q > ONE_LR) begin
				desat_r = right_q - (left_q - ONE_LR);
				desat_l = ONE_LR;
			end else if (right_q > ONE_LR) begin
				desat_l = left_q - (right_q - ONE_LR);
				desat_r = ONE_LR;
			end else if (left_q < -ONE_LR) begin
				desat_r = right_q - (left_q + ONE_LR);
				desat_l = -ONE_LR;
			end else if (right_q < -ONE_LR) begin
				desat_l = left_q - (right_q + ONE_LR);
				desat_r = -ONE_LR;
			end
		end
	end

	assign mag_l = left_q[LR_W-1]  ? LR_W'(-left_q)  : LR_W'(left_q);
	assign mag_r = right_q[LR_W-1] ? LR_W'(-right_q) : LR_W'(right_q);
	assign big   = (mag_l > mag_r) ? mag_l : mag_r;

	// One restoring quotient bit per step for each side.
	assign ge_l   = rem_l_q >= REM_W'(big_q);
	assign ge_r   = rem_r_q >= REM_W'(big_q);
	assign diff_l = ge_l ? rem_l_q - REM_W'(big_q) : rem_l_q;
	assign diff_r = ge_r ? rem_r_q - REM_W'(big_q) : rem_r_q;

	assign q_l = sign_l_q ? -$signed(IO_W'(quo_l_q)) : $signed(IO_W'(quo_l_q));
	assign q_r = sign_r_q ? -$signed(IO_W'(quo_r_q)) : $signed(IO_W'(quo_r_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= THRESHOLD_RST;
			alpha_q    <= ALPHA_RST;
			acc_q      <= '0;
			need_div_q <= 1'b0;
		end else begin
			if (cfg.en) begin
				unique case (cfg.index)
					REG_THRESHOLD: thresh_q <= cfg.data;
					REG_ALPHA:     alpha_q  <= cfg.data;
					default: ;
				endcase
			end
			if (cmd.mix) begin
				if (quick_q) begin
					if (below_q) begin
						acc_q <= filt_sat;
					end
				end else begin
					priority if (acc_q > ONE_ACC) begin
						acc_q <= acc_q - ONE_ACC;
					end else if (acc_q < -ONE_ACC) begin
						acc_q <= acc_q + ONE_ACC;
					end else begin
						acc_q <= '0;
					end
				end
			end
			if (cmd.norm) begin
				need_div_q <= big > LR_W'(ONE_LR);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			thr_q     <= in_data.throttle;
			rot_q     <= in_data.rotation;
			quick_q   <= in_data.quick_turn;
			mag_thr_q <= mag_thr;
			below_q   <= mag_thr < (IO_W + 1)'(thresh_q);
		end
		if (cmd.mul_a) begin
			prod_a_q <= prod;
		end
		if (cmd.mul_b) begin
			prod_b_q <= prod;
		end
		if (cmd.mix) begin
			left_q  <= LR_W'(thr_q) + ang;
			right_q <= LR_W'(thr_q) - ang;
		end
		if (cmd.desat) begin
			left_q  <= desat_l;
			right_q <= desat_r;
		end
		if (cmd.norm) begin
			big_q    <= big;
			sign_l_q <= left_q[LR_W-1];
			sign_r_q <= right_q[LR_W-1];
			rem_l_q  <= REM_W'(mag_l);
			rem_r_q  <= REM_W'(mag_r);
			quo_l_q  <= '0;
			quo_r_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_l_q <= diff_l << 1;
			rem_r_q <= diff_r << 1;
			quo_l_q <= {quo_l_q[QUO_W-2:0], ge_l};
			quo_r_q <= {quo_r_q[QUO_W-2:0], ge_r};
		end
		if (cmd.out_load) begin
			if (need_div_q) begin
				out_q.left_power  <= q_l;
				out_q.right_power <= q_r;
			end else begin
				out_q.left_power  <= IO_W'(left_q);
				out_q.right_power <= IO_W'(right_q);
			end
		end
	end

endmodule

// File: src/curvature_drive_mixer.sv
// ----------------------------------------------------------------------------
// curvature_drive_mixer
// Curvature drive mixer with quick turn: turns throttle and rotation into
// left and right side powers, with a quick-stop accumulator and normalization.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                              Direction  Beat
//  -------  -----------------------------------  ---------  --------------------
//  in       in_valid, in_ready, in_data          sink       throttle, rotation, mode
//  out      out_valid, out_ready, out_data       source     left and right power
//  cfg      cfg_valid, cfg_ready, cfg_index/data sink       one register write
//
// One beat is processed at a time, through the multiply, mix, desaturate,
// normalize, divide and done steps. When the larger side exceeds full power,
// two radix-2 dividers run one quotient bit per cycle for FRAC_BITS + 1 bits;
// else the divide step ends at once. The input is taken again the cycle after
// the result enters the output register, and the output register lets the
// next beat start while a result still waits for out_ready. Reset is
// asynchronous: the control, configuration and division-flag registers reset
// and the accumulator clears; data registers have none. A stalled output
// holds the sequencer in its last step. Configuration writes are always taken;
// indexes past the last register are dropped.
module curvature_drive_mixer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cdm_pkg::in_beat_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cdm_pkg::out_beat_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cdm_pkg::CFG_W-1:0]     cfg_data
);
	import cdm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	cfg_wr_t    cfg;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;
	assign cfg.en    = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// The controller sequences the steps and holds the output valid flag.
	cdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the accumulator, configuration and all arithmetic.
	cdm_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

	// A taken beat keeps the input closed for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted again right after a beat");

	// A beat is still at work several steps later.
	a_busy_through_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##4 !in_ready)
		else $error("input reopened before the beat finished");

	// A result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register loaded while a result was pending");

	// The result register is filled only while the input is closed.
	a_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !in_ready)
		else $error("result loaded while the input was open");

endmodule
